// ===== rtl/core/sitbs_pkg.sv =====
// ----------------------------------------------------------------------------
// sitbs_pkg - shared constants for the signed integer to base symbols block
//
// Default sizes, character codes and configuration register indexes.
// ----------------------------------------------------------------------------
package sitbs_pkg;

  // default sizes
  localparam int MAX_SYMBOLS_DEF = 16;
  localparam int VALUE_BITS_DEF  = 32;

  // port widths fixed by the payload
  localparam int IN_VALUE_W = 32;
  localparam int SYMBOL_W   = 8;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  // quotient bits resolved per divider cycle
  localparam int DIV_BITS_PER_CYCLE = 4;

  // character codes
  localparam logic [SYMBOL_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [SYMBOL_W-1:0] CHAR_MINUS = 8'h2D;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd1;

endpackage

// ===== rtl/core/signed_int_to_base_symbols.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_base_symbols - signed integer to text in a configured base
//
// Checks the symbol table, divides the magnitude by the base digit by digit
// on one shared restoring divider, then streams '-' and the digits out.
// ----------------------------------------------------------------------------
// One value is handled at a time and in_ready is low from acceptance until
// its last character has been loaded into the output register. Each value
// goes through the table scan, the repeated-symbol check (pairwise over the
// n symbols of base n), the divider, which resolves four quotient bits per
// cycle, and then the output of D digits plus one for a negative sign, which
// can stall on out_ready. A rejected table returns to idle after the scan or
// check with no characters.
module signed_int_to_base_symbols #(
  parameter int MAX_SYMBOLS = sitbs_pkg::MAX_SYMBOLS_DEF,
  parameter int VALUE_BITS  = sitbs_pkg::VALUE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration
  input  logic                                  cfg_we,
  input  logic [sitbs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sitbs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // input beat
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [sitbs_pkg::IN_VALUE_W-1:0] in_value,
  // output beat
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [sitbs_pkg::SYMBOL_W-1:0]        out_symbol,
  output logic                                  out_last
);

  localparam int SYM_IDX_W = $clog2(MAX_SYMBOLS);
  localparam int BASE_W    = $clog2(MAX_SYMBOLS + 1);
  localparam int REM_W     = SYM_IDX_W + 1;
  localparam int BPC       = sitbs_pkg::DIV_BITS_PER_CYCLE;
  localparam int DIV_STEPS = (VALUE_BITS + BPC - 1) / BPC;
  localparam int DIV_W     = DIV_STEPS * BPC;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int DIG_IDX_W = $clog2(VALUE_BITS);
  localparam int CNT_W     = $clog2(VALUE_BITS + 1);

  typedef logic [SYM_IDX_W-1:0]           idx_t;
  typedef logic [BASE_W-1:0]              base_t;
  typedef logic [REM_W-1:0]               rem_t;
  typedef logic [DIV_W-1:0]               work_t;
  typedef logic [STEP_W-1:0]              step_t;
  typedef logic [CNT_W-1:0]               cnt_t;
  typedef logic [sitbs_pkg::SYMBOL_W-1:0] sym_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DUP,
    S_DIV,
    S_EMIT
  } state_t;

  state_t      state_r, state_nxt;
  sym_t        sym_r [MAX_SYMBOLS];
  base_t       scan_r, scan_nxt;
  base_t       base_r, base_nxt;
  idx_t        dup_i_r, dup_i_nxt;
  idx_t        dup_j_r, dup_j_nxt;
  work_t       work_r, work_nxt;
  idx_t        rem_r, rem_nxt;
  step_t       step_r, step_nxt;
  logic        neg_r, neg_nxt;
  logic        sign_pend_r, sign_pend_nxt;
  idx_t        digit_r [VALUE_BITS];
  cnt_t        cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  sym_t        out_symbol_r, out_symbol_nxt;
  logic        out_last_r, out_last_nxt;

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;
  sym_t        scan_byte;
  logic        dup_hit;
  logic        out_free;
  cnt_t        cnt_m1;
  work_t       div_w;
  idx_t        div_r;
  logic        digit_we;

  // operand capture
  assign raw = in_value[VALUE_BITS-1:0];
  assign mag = raw[VALUE_BITS-1] ? (VALUE_BITS'(0) - raw) : raw;

  assign scan_byte = sym_r[scan_r[SYM_IDX_W-1:0]];
  assign dup_hit   = (sym_r[dup_i_r] == sym_r[dup_j_r]);
  assign out_free  = !out_valid_r || out_ready;
  assign cnt_m1    = cnt_r - cnt_t'(1);

  // shared divider: four restoring steps per cycle on a narrow remainder
  always_comb begin
    rem_t t;
    work_t w;
    idx_t r;
    w = work_r;
    r = rem_r;
    for (int s = 0; s < BPC; s++) begin
      t = {r, w[DIV_W-1]};
      w = {w[DIV_W-2:0], 1'b0};
      if (t >= rem_t'(base_r)) begin
        t    = t - rem_t'(base_r);
        w[0] = 1'b1;
      end
      r = t[SYM_IDX_W-1:0];
    end
    div_w = w;
    div_r = r;
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    scan_nxt       = scan_r;
    base_nxt       = base_r;
    dup_i_nxt      = dup_i_r;
    dup_j_nxt      = dup_j_r;
    work_nxt       = work_r;
    rem_nxt        = rem_r;
    step_nxt       = step_r;
    neg_nxt        = neg_r;
    sign_pend_nxt  = sign_pend_r;
    cnt_nxt        = cnt_r;
    digit_we       = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_symbol_nxt = out_symbol_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          neg_nxt   = raw[VALUE_BITS-1];
          work_nxt  = work_t'(mag);
          scan_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end

      // find the base and reject sign characters and bases under two
      S_SCAN: begin
        if (scan_r == base_t'(MAX_SYMBOLS) || scan_byte == '0) begin
          base_nxt  = scan_r;
          dup_i_nxt = idx_t'(0);
          dup_j_nxt = idx_t'(1);
          state_nxt = (scan_r < base_t'(2)) ? S_IDLE : S_DUP;
        end else if (scan_byte == sitbs_pkg::CHAR_PLUS ||
                     scan_byte == sitbs_pkg::CHAR_MINUS) begin
          state_nxt = S_IDLE;
        end else begin
          scan_nxt = scan_r + base_t'(1);
        end
      end

      // pairwise check for repeated symbols
      S_DUP: begin
        if (dup_hit) begin
          state_nxt = S_IDLE;
        end else if (base_t'(dup_j_r) == base_r - base_t'(1)) begin
          if (base_t'(dup_i_r) == base_r - base_t'(2)) begin
            rem_nxt       = '0;
            step_nxt      = '0;
            sign_pend_nxt = neg_r;
            state_nxt     = S_DIV;
          end else begin
            dup_i_nxt = dup_i_r + idx_t'(1);
            dup_j_nxt = dup_i_r + idx_t'(2);
          end
        end else begin
          dup_j_nxt = dup_j_r + idx_t'(1);
        end
      end

      // one digit per divider pass, least significant first
      S_DIV: begin
        work_nxt = div_w;
        rem_nxt  = div_r;
        if (step_r == step_t'(DIV_STEPS - 1)) begin
          digit_we = 1'b1;
          cnt_nxt  = cnt_r + cnt_t'(1);
          rem_nxt  = '0;
          step_nxt = '0;
          if (div_w == '0) begin
            state_nxt = S_EMIT;
          end
        end else begin
          step_nxt = step_r + step_t'(1);
        end
      end

      // sign first, then digits most significant first
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (sign_pend_r) begin
            out_symbol_nxt = sitbs_pkg::CHAR_MINUS;
            out_last_nxt   = 1'b0;
            sign_pend_nxt  = 1'b0;
          end else begin
            out_symbol_nxt = sym_r[digit_r[cnt_m1[DIG_IDX_W-1:0]]];
            out_last_nxt   = (cnt_r == cnt_t'(1));
            cnt_nxt        = cnt_m1;
            if (cnt_r == cnt_t'(1)) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // state, registered outputs, table and digit store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sign_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < MAX_SYMBOLS; k++) begin
        sym_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sign_pend_r <= sign_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        for (int k = 0; k < MAX_SYMBOLS; k++) begin
          if (k < 8 && cfg_index == sitbs_pkg::CFG_SYMBOLS_LOW) begin
            sym_r[k] <= cfg_wdata[(k % 8) * 8 +: 8];
          end else if (k >= 8 && cfg_index == sitbs_pkg::CFG_SYMBOLS_HIGH) begin
            sym_r[k] <= cfg_wdata[(k % 8) * 8 +: 8];
          end
        end
      end
    end
    scan_r       <= scan_nxt;
    base_r       <= base_nxt;
    dup_i_r      <= dup_i_nxt;
    dup_j_r      <= dup_j_nxt;
    work_r       <= work_nxt;
    rem_r        <= rem_nxt;
    step_r       <= step_nxt;
    neg_r        <= neg_nxt;
    out_symbol_r <= out_symbol_nxt;
    out_last_r   <= out_last_nxt;
    if (digit_we) begin
      digit_r[cnt_r[DIG_IDX_W-1:0]] <= div_r;
    end
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;

  // checks
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (cnt_r == '0) && !sign_pend_r)
    else $error("idle with characters still pending");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cnt_t'(VALUE_BITS))
    else $error("digit count beyond value width");

  a_div_base: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (base_r >= base_t'(2)) && (base_t'(rem_r) < base_r))
    else $error("divider running with bad base or remainder");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (cnt_r != '0))
    else $error("emit state with no digits");

endmodule
